[rtl/core/ps2sc_pkg.sv]
// Shared types, byte codes and key tables for the PS/2 set 2 scan code decoder.
// No dependencies; every other file in rtl/core refers to this package by scope.

package ps2sc_pkg;

	localparam logic [7:0] CODE_EXT     = 8'hE0;
	localparam logic [7:0] CODE_PAUSE   = 8'hE1;
	localparam logic [7:0] CODE_BREAK   = 8'hF0;
	localparam logic [7:0] CODE_PAUSE_2 = 8'h14;
	localparam logic [7:0] CODE_PAUSE_3 = 8'h77;

	localparam int QUEUE_DEPTH = 2;

	// One classified key event as it travels from the front part to the back part.
	typedef struct packed {
		logic       ext;
		logic       pause;
		logic [7:0] code;
		logic       pressed;
	} evt_t;

	// One finished result item.
	typedef struct packed {
		logic       known;
		logic       ext;
		logic       pause;
		logic [7:0] code;
		logic       pressed;
	} key_t;

	function automatic logic is_plain_key(input logic [7:0] b);
		logic hit;
		case (b) inside
			8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C,
			8'h0D, 8'h0E, 8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C,
			8'h1D, 8'h1E, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A,
			8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
			8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45,
			8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h52, 8'h54, 8'h55,
			8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5D, 8'h66, 8'h69, 8'h6C, 8'h70, 8'h71,
			8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B,
			8'h7C, 8'h7D, 8'h7E, 8'h83: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic logic is_ext_key(input logic [7:0] b);
		logic hit;
		case (b) inside
			8'h10, 8'h11, 8'h14, 8'h15, 8'h18, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h27,
			8'h28, 8'h2B, 8'h2F, 8'h30, 8'h32, 8'h34, 8'h38, 8'h3A, 8'h3B, 8'h40,
			8'h48, 8'h4A, 8'h4D, 8'h50, 8'h5A, 8'h69, 8'h6B, 8'h6C, 8'h70, 8'h71,
			8'h72, 8'h74, 8'h75, 8'h7A, 8'h7D: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

[rtl/core/ps2sc_front.sv]
// Front part of the scan code decoder: accepts bytes, tracks the prefix state
// and the release flag, and pushes one event per completed key. Uses ps2sc_pkg.

module ps2sc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               acc,
	input  logic [7:0]         rx_byte,
	output logic               push,
	output ps2sc_pkg::evt_t    evt
);

	typedef enum logic [1:0] {
		PFX_NONE,
		PFX_E0,
		PFX_E1,
		PFX_E1_14
	} pfx_t;

	logic scan_enable_q;
	pfx_t prefix_q, prefix_d;
	logic press_q, press_d;

	always_comb begin
		prefix_d    = prefix_q;
		press_d     = press_q;
		push        = 1'b0;
		evt.ext     = 1'b0;
		evt.pause   = 1'b0;
		evt.code    = rx_byte;
		evt.pressed = press_q;
		if (acc && scan_enable_q) begin
			if (rx_byte == ps2sc_pkg::CODE_EXT) begin
				prefix_d = PFX_E0;
			end else if (rx_byte == ps2sc_pkg::CODE_PAUSE) begin
				prefix_d = PFX_E1;
			end else if (rx_byte == ps2sc_pkg::CODE_BREAK) begin
				press_d = 1'b0;
			end else begin
				unique case (prefix_q)
					PFX_NONE: begin
						push = 1'b1;
					end
					PFX_E0: begin
						push     = 1'b1;
						evt.ext  = 1'b1;
						prefix_d = PFX_NONE;
					end
					PFX_E1: begin
						if (rx_byte == ps2sc_pkg::CODE_PAUSE_2) begin
							prefix_d = PFX_E1_14;
						end else begin
							prefix_d = PFX_NONE;
							press_d  = 1'b1;
						end
					end
					PFX_E1_14: begin
						prefix_d = PFX_NONE;
						if (rx_byte == ps2sc_pkg::CODE_PAUSE_3) begin
							push      = 1'b1;
							evt.pause = 1'b1;
						end else begin
							press_d = 1'b1;
						end
					end
					default: begin
						prefix_d = PFX_NONE;
					end
				endcase
				if (push) begin
					press_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q <= 1'b0;
			prefix_q      <= PFX_NONE;
			press_q       <= 1'b1;
		end else begin
			if (cfg_we) begin
				scan_enable_q <= cfg_wdata;
			end
			prefix_q <= prefix_d;
			press_q  <= press_d;
		end
	end

`ifndef SYNTHESIS
	a_break_clears_press: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && scan_enable_q && rx_byte == ps2sc_pkg::CODE_BREAK) |=> !press_q)
		else $error("break code did not clear the press flag");
	a_pause_event_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(push && evt.pause) |-> (!evt.ext && evt.code == ps2sc_pkg::CODE_PAUSE_3))
		else $error("malformed pause event");
	a_no_push_when_off: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> scan_enable_q)
		else $error("event pushed while scanning is disabled");
`endif

endmodule

[rtl/core/ps2sc_queue.sv]
// Short event queue between the front and back parts of the decoder.
// Register array with read and write pointers; uses ps2sc_pkg for the entry type.

module ps2sc_queue #(
	parameter int DEPTH = ps2sc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ps2sc_pkg::evt_t wr_data,
	input  logic            pop,
	output ps2sc_pkg::evt_t rd_data,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ps2sc_pkg::evt_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
	a_ptrs_meet_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/core/ps2sc_back.sv]
// Back part of the decoder: takes events from the queue, looks the key up in the
// plain or extended table and holds the result in the output register. Uses ps2sc_pkg.

module ps2sc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  ps2sc_pkg::evt_t q_data,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output ps2sc_pkg::key_t out_key
);

	logic            out_valid_q;
	ps2sc_pkg::key_t out_key_q;
	ps2sc_pkg::key_t key_d;

	// The output register reloads, if the queue holds an event, whenever it is empty or being drained.
	assign q_pop = !q_empty && (!out_valid_q || out_ready);

	always_comb begin
		key_d.ext     = q_data.ext;
		key_d.pause   = q_data.pause;
		key_d.code    = q_data.code;
		key_d.pressed = q_data.pressed;
		if (q_data.pause) begin
			key_d.known = 1'b1;
		end else if (q_data.ext) begin
			key_d.known = ps2sc_pkg::is_ext_key(q_data.code);
		end else begin
			key_d.known = ps2sc_pkg::is_plain_key(q_data.code);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_key_q <= key_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_key   = out_key_q;

`ifndef SYNTHESIS
	a_pause_known: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_key_q.pause) |-> out_key_q.known)
		else $error("pause result not marked known");
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !q_pop)
		else $error("queue popped while the result is stalled");
`endif

endmodule

[rtl/core/ps2_set2_scancode_decoder.sv]
// A completed key event is written into the event queue and from there loaded
// into the output register, where the receiver takes it.
// Throughput: one byte per cycle; the input stalls only when the output is held
// off long enough to fill the event queue (QUEUE_DEPTH entries).
// Prefix bytes, F0 and broken pause sequences produce no output transaction.
// Reset (arst_n low, asynchronous): scanning disabled, no prefix, press flag set,
// queue and output register empty.

module ps2_set2_scancode_decoder #(
	parameter int QUEUE_DEPTH = ps2sc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // scan_enable
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] key_known, [1] key_extended, [2] key_pause, [10:3] make_byte,
	// [11] key_pressed, [15:12] zero
	output logic [15:0] m_axis_tdata
);

	logic            acc;
	logic            push;
	ps2sc_pkg::evt_t evt;
	ps2sc_pkg::evt_t q_data;
	logic            q_full, q_empty, q_pop;
	ps2sc_pkg::key_t out_key;

	assign s_axis_tready = !q_full;
	assign acc           = s_axis_tvalid && s_axis_tready;

	ps2sc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.rx_byte   (s_axis_tdata),
		.push      (push),
		.evt       (evt)
	);

	ps2sc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (evt),
		.pop     (q_pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	ps2sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_key   (out_key)
	);

	assign m_axis_tdata = {4'b0000, out_key.pressed, out_key.code, out_key.pause,
		out_key.ext, out_key.known};

endmodule

[sim/tb_ps2_set2_scancode_decoder.sv]
// Self-checking testbench for ps2_set2_scancode_decoder: directed and random stream
// traffic; an in-bench set 2 decoder predicts every key event. Needs ps2sc_pkg, the RTL.
`timescale 1ns / 100ps

module tb_ps2_set2_scancode_decoder;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_EXT, SEQ_PAUSE, SEQ_PAUSE_14} seq_t;

	localparam int CLK_PERIOD   = 10;
	localparam int GAP_PCT      = 24;
	localparam int TARGET_BYTES = 850;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 4;
	localparam logic [7:0] CODE_TOP_KEY = 8'h83;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] rx_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [0] key_known, [1] key_extended, [2] key_pause, [10:3] make_byte,
	// [11] key_pressed, [15:12] zero
	logic [15:0] m_axis_tdata;

	ps2_set2_scancode_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	bit [7:0] plain_codes[$] = '{
		8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E,
		8'h11, 8'h12, 8'h14, 8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
		8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h2E,
		8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
		8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E,
		8'h52, 8'h54, 8'h55, 8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5D, 8'h66, 8'h69, 8'h6C,
		8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h7B,
		8'h7C, 8'h7D, 8'h7E, CODE_TOP_KEY
	};
	bit [7:0] ext_codes[$] = '{
		8'h10, 8'h11, 8'h14, 8'h15, 8'h18, 8'h1F, 8'h20, 8'h21, 8'h23, 8'h27, 8'h28, 8'h2B,
		8'h2F, 8'h30, 8'h32, 8'h34, 8'h38, 8'h3A, 8'h3B, 8'h40, 8'h48, 8'h4A, 8'h4D, 8'h50,
		8'h5A, 8'h69, 8'h6B, 8'h6C, 8'h70, 8'h71, 8'h72, 8'h74, 8'h75, 8'h7A, 8'h7D
	};

	// Decoder state as the bench sees it.
	logic  scan_on = 1'b0;
	seq_t  seq_state = SEQ_IDLE;
	logic  press_pending = 1'b1;

	logic [7:0]      rx_pending[$];
	ps2sc_pkg::key_t expected_keys[$];
	int              mismatch_count = 0;
	int              fed_bytes = 0;
	int              gap_pct = GAP_PCT;
	bit              byte_taken = 1'b0;
	bit              rx_hold = 1'b0;
	bit              random_started = 1'b0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic bit code_listed(input logic [7:0] b, input bit extended);
		bit hit;
		hit = 1'b0;
		if (extended) begin
			foreach (ext_codes[i]) if (ext_codes[i] == b) hit = 1'b1;
		end else begin
			foreach (plain_codes[i]) if (plain_codes[i] == b) hit = 1'b1;
		end
		return hit;
	endfunction

	// Advances the bench's decoder by one accepted byte and queues any key event.
	task automatic decode_scan_byte(input logic [7:0] b);
		ps2sc_pkg::key_t k;
		bit              emit;
		k = '0;
		emit = 1'b0;
		if (!scan_on) return;
		if (b == ps2sc_pkg::CODE_EXT) begin
			seq_state = SEQ_EXT;
		end else if (b == ps2sc_pkg::CODE_PAUSE) begin
			seq_state = SEQ_PAUSE;
		end else if (b == ps2sc_pkg::CODE_BREAK) begin
			press_pending = 1'b0;
		end else begin
			case (seq_state)
				SEQ_IDLE: begin
					k.known = code_listed(b, 1'b0);
					emit = 1'b1;
				end
				SEQ_EXT: begin
					k.known = code_listed(b, 1'b1);
					k.ext = 1'b1;
					seq_state = SEQ_IDLE;
					emit = 1'b1;
				end
				SEQ_PAUSE: begin
					if (b == ps2sc_pkg::CODE_PAUSE_2) begin
						seq_state = SEQ_PAUSE_14;
					end else begin
						seq_state = SEQ_IDLE;
						press_pending = 1'b1;
					end
				end
				default: begin
					seq_state = SEQ_IDLE;
					if (b == ps2sc_pkg::CODE_PAUSE_3) begin
						k.known = 1'b1;
						k.pause = 1'b1;
						emit = 1'b1;
					end else begin
						press_pending = 1'b1;
					end
				end
			endcase
			if (emit) begin
				k.code = b;
				k.pressed = press_pending;
				press_pending = 1'b1;
				expected_keys.push_back(k);
			end
		end
	endtask

	task automatic check_key(input logic [15:0] d);
		ps2sc_pkg::key_t want;
		if (expected_keys.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: key event %h with none outstanding", $realtime, d);
		end else begin
			want = expected_keys.pop_front();
			if (d[0] !== want.known || d[1] !== want.ext || d[2] !== want.pause ||
					d[10:3] !== want.code || d[11] !== want.pressed || d[15:12] !== 4'h0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"%0t: key event mismatch: known/ext/pause/code/pressed ",
						"expected %b/%b/%b/%h/%b, got %b/%b/%b/%h/%b (pad %h)"},
						$realtime, want.known, want.ext, want.pause, want.code, want.pressed,
						d[0], d[1], d[2], d[10:3], d[11], d[15:12]);
			end
		end
	endtask

	// Monitor: sample both handshakes and the register write at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) check_key(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) begin
				decode_scan_byte(s_axis_tdata);
				byte_taken = 1'b1;
			end
			if (cfg_we) scan_on = cfg_wdata;
		end
	end

	// Driver: present bytes from the pending queue, with random gaps.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || byte_taken)) begin
			if (rx_pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= rx_pending.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		byte_taken = 1'b0;
	end

	// Receiver ready, with random stalls and the long hold-off.
	always @(negedge clk) begin
		if (arst_n)
			m_axis_tready <= !rx_hold && ($urandom_range(99) >= gap_pct);
	end

	// Long receiver hold-off early in the random traffic, so the event queue fills up.
	initial begin
		wait (random_started);
		repeat (40) @(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic write_scan_enable(input logic v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every byte is taken and every key event has arrived, then lets
	// the pipeline settle so that trailing prefix bytes are fully absorbed.
	task automatic wait_quiet();
		int guard;
		guard = 0;
		while ((rx_pending.size() != 0 || s_axis_tvalid || expected_keys.size() != 0)
				&& guard < 5000) begin
			@(negedge clk);
			if (rx_pending.size() == 0 && !s_axis_tvalid) guard++;
		end
		if (expected_keys.size() != 0) begin
			mismatch_count += expected_keys.size();
			if (mismatch_count <= 10)
				$display("%0t: %0d key events never arrived", $realtime, expected_keys.size());
			expected_keys.delete();
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic feed(input logic [7:0] b);
		rx_pending.push_back(b);
		if (scan_on) fed_bytes++;
	endtask

	function automatic logic [7:0] pick_key(input bit extended);
		if ($urandom_range(99) < 15) return 8'($urandom_range(255));
		if (extended) return ext_codes[$urandom_range(ext_codes.size() - 1)];
		return plain_codes[$urandom_range(plain_codes.size() - 1)];
	endfunction

	// Mostly well-formed key sequences with random content, plus broken pause
	// sequences and raw noise.
	task automatic feed_sequence();
		int sel;
		int n;
		sel = $urandom_range(99);
		if (sel < 40) begin
			if ($urandom_range(99) < 40) feed(ps2sc_pkg::CODE_BREAK);
			feed(pick_key(1'b0));
		end else if (sel < 60) begin
			feed(ps2sc_pkg::CODE_EXT);
			if ($urandom_range(99) < 40) feed(ps2sc_pkg::CODE_BREAK);
			feed(pick_key(1'b1));
		end else if (sel < 68) begin
			if ($urandom_range(1)) begin
				feed(ps2sc_pkg::CODE_BREAK);
				feed(ps2sc_pkg::CODE_PAUSE);
			end else begin
				feed(ps2sc_pkg::CODE_PAUSE);
				if ($urandom_range(1)) feed(ps2sc_pkg::CODE_BREAK);
			end
			feed(ps2sc_pkg::CODE_PAUSE_2);
			feed(ps2sc_pkg::CODE_PAUSE_3);
		end else if (sel < 80) begin
			feed(ps2sc_pkg::CODE_PAUSE);
			if ($urandom_range(1)) feed(ps2sc_pkg::CODE_PAUSE_2);
			feed(8'($urandom_range(255)));
		end else begin
			n = $urandom_range(3, 1);
			repeat (n) feed(8'($urandom_range(255)));
		end
	endtask

	task automatic feed_random(input int count);
		int stop_at;
		stop_at = fed_bytes + count;
		@(posedge clk);
		while (fed_bytes < stop_at) feed_sequence();
		wait_quiet();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Scanning off after reset: everything is dropped.
		write_scan_enable(1'b0);
		@(posedge clk);
		repeat (12) rx_pending.push_back(8'($urandom_range(255)));
		rx_pending.push_back(8'h1C);
		wait_quiet();

		write_scan_enable(1'b1);
		@(posedge clk);
		// Field extremes and the top of the plain table.
		feed(8'h00); feed(8'hFF); feed(CODE_TOP_KEY);
		// Release, extended press and release, and break before the prefix.
		feed(ps2sc_pkg::CODE_BREAK); feed(8'h1C);
		feed(ps2sc_pkg::CODE_EXT); feed(8'h7D);
		feed(ps2sc_pkg::CODE_EXT); feed(ps2sc_pkg::CODE_BREAK); feed(8'h75);
		feed(ps2sc_pkg::CODE_BREAK); feed(ps2sc_pkg::CODE_EXT); feed(8'h00);
		// Pause press, pause release.
		feed(ps2sc_pkg::CODE_PAUSE); feed(ps2sc_pkg::CODE_PAUSE_2);
		feed(ps2sc_pkg::CODE_PAUSE_3);
		feed(ps2sc_pkg::CODE_BREAK); feed(ps2sc_pkg::CODE_PAUSE);
		feed(ps2sc_pkg::CODE_PAUSE_2); feed(ps2sc_pkg::CODE_PAUSE_3);
		wait_quiet();
		@(posedge clk);
		// Broken pause sequences; the second one also clears a pending release.
		feed(ps2sc_pkg::CODE_PAUSE); feed(8'h55); feed(8'h29);
		feed(ps2sc_pkg::CODE_BREAK); feed(ps2sc_pkg::CODE_PAUSE);
		feed(ps2sc_pkg::CODE_PAUSE_2); feed(8'h12); feed(8'h29);
		// A new prefix overrides a pause sequence in progress.
		feed(ps2sc_pkg::CODE_PAUSE); feed(ps2sc_pkg::CODE_EXT); feed(8'h75);
		feed(ps2sc_pkg::CODE_PAUSE); feed(ps2sc_pkg::CODE_PAUSE_2);
		feed(ps2sc_pkg::CODE_PAUSE); feed(ps2sc_pkg::CODE_PAUSE_2);
		feed(ps2sc_pkg::CODE_PAUSE_3);
		// Leave an E0 and a release pending across a disabled stretch.
		feed(ps2sc_pkg::CODE_EXT); feed(ps2sc_pkg::CODE_BREAK);
		wait_quiet();
		write_scan_enable(1'b0);
		@(posedge clk);
		rx_pending.push_back(8'h5A);
		rx_pending.push_back(ps2sc_pkg::CODE_PAUSE);
		rx_pending.push_back(8'h33);
		wait_quiet();
		write_scan_enable(1'b1);
		@(posedge clk);
		feed(8'h5A);
		wait_quiet();

		random_started = 1'b1;
		feed_random(300);

		@(posedge clk);
		gap_pct = 0;
		feed_random(200);
		@(posedge clk);
		gap_pct = GAP_PCT;

		// Random bytes while scanning is off must leave no trace.
		write_scan_enable(1'b0);
		@(posedge clk);
		repeat (40) rx_pending.push_back(8'($urandom_range(255)));
		wait_quiet();
		write_scan_enable(1'b1);

		feed_random(TARGET_BYTES - fed_bytes);
		repeat (20) @(negedge clk);

		if (mismatch_count == 0 && expected_keys.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
